/* design/fpr_pkg.sv */
// Shared request and result types and codes for the flag partition renumber block.
package fpr_pkg;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_REMAP = 1'b1;

  localparam int REF_W  = 12;
  localparam int SLOT_W = 11;

  typedef struct packed {
    logic                     kind;
    logic                     flag;
    logic                     last;
    logic signed [REF_W-1:0]  face_ref;
  } req_t;

  typedef struct packed {
    logic                     result_kind;
    logic        [SLOT_W-1:0] boundary_slot;
    logic signed [REF_W-1:0]  mapped_ref;
  } rsp_t;

endpackage

/* design/fpr_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module fpr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/flag_partition_renumber.sv */
// Top level: face flag load, two-pointer partition and face reference remap.
//
//  channel   handshake        payload             direction
//  request   start / busy     fpr_pkg::req_t      in
//  result    strobe           fpr_pkg::rsp_t      out
//
// A load without the last mark is written straight into the flag RAM while there is room.
// A remap is answered from the registered read of the swap map RAM, or passed through on a miss.
// A load with the last mark keeps busy high through the partition run; the single read port of
// the flag RAM sets the pace, and the boundary report ends that run.
// Reset clears the face count and the map-ready mark; RAM contents are not cleared.
// Results cannot be stalled: each strobe lasts exactly one cycle.
module flag_partition_renumber #(
  parameter int MAX_FACES = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fpr_pkg::req_t request,
  output logic          strobe,
  output fpr_pkg::rsp_t result
);

  import fpr_pkg::*;

  localparam int AW   = $clog2(MAX_FACES);
  localparam int CW   = $clog2(MAX_FACES + 2);
  localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_QRES, ST_START, ST_IRD, ST_ICHK, ST_JRD, ST_JCHK, ST_SW1, ST_SW2, ST_RPT
  } state_t;

  state_t state;

  logic [CW-1:0] face_count, marked, first_face;
  logic          map_ready;
  logic [CW-1:0] ptr_i, ptr_hi, ptr_j;
  logic          q_hit;
  logic signed [REF_W-1:0] q_ref;

  logic          accept;
  logic [CW-1:0] cnt_base, mk_base, fst_base;
  logic          room;
  logic          ref_pos, hit;
  logic [SLOT_W-1:0] ref_m1;

  logic          flag_we, flag_re, flag_rdata;
  logic [AW-1:0] flag_waddr, flag_raddr;
  logic          map_we, map_re;
  logic [AW-1:0] map_waddr, map_raddr;
  logic [CW-1:0] map_wdata, map_rdata;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // a load after a finished map restarts the count
  assign cnt_base = map_ready ? '0 : face_count;
  assign mk_base  = map_ready ? '0 : marked;
  assign fst_base = map_ready ? '0 : first_face;
  assign room     = (cnt_base < CW'(MAX_FACES));

  assign ref_pos = !request.face_ref[REF_W-1] && (request.face_ref != '0);
  assign ref_m1  = request.face_ref[SLOT_W-1:0] - SLOT_W'(1);
  assign hit     = map_ready && ref_pos &&
                   (CMPW'(request.face_ref[SLOT_W-1:0]) <= CMPW'(face_count));

  assign flag_we    = accept && (request.kind == KIND_LOAD) && room;
  assign flag_waddr = AW'(cnt_base);
  assign flag_re    = ((state == ST_IRD) && (ptr_i <= face_count)) || (state == ST_JRD);
  assign flag_raddr = (state == ST_JRD) ? AW'(ptr_j - CW'(1)) : AW'(ptr_i - CW'(1));

  assign map_re    = accept && (request.kind == KIND_REMAP);
  assign map_raddr = AW'(ref_m1);

  always_comb begin
    map_we    = 1'b0;
    map_waddr = AW'(cnt_base);
    map_wdata = cnt_base + CW'(1);
    case (state)
      ST_IDLE: begin
        map_we = flag_we;
      end
      ST_SW1: begin
        map_we    = 1'b1;
        map_waddr = AW'(ptr_i - CW'(1));
        map_wdata = ptr_j;
      end
      ST_SW2: begin
        map_we    = 1'b1;
        map_waddr = AW'(ptr_j - CW'(1));
        map_wdata = ptr_i;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  fpr_ram #(.DEPTH(MAX_FACES), .WIDTH(1)) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (request.flag),
    .re    (flag_re),
    .raddr (flag_raddr),
    .rdata (flag_rdata)
  );

  fpr_ram #(.DEPTH(MAX_FACES), .WIDTH(CW)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      strobe     <= 1'b0;
      map_ready  <= 1'b0;
      face_count <= '0;
      marked     <= '0;
      first_face <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (request.kind == KIND_LOAD) begin
              map_ready <= 1'b0;
              if (room) begin
                face_count <= cnt_base + CW'(1);
                marked     <= request.flag ? mk_base + CW'(1) : mk_base;
                first_face <= (request.flag && (fst_base == '0)) ? cnt_base + CW'(1)
                                                                 : fst_base;
              end else begin
                // drop the flag, keep the count at its limit
                face_count <= cnt_base;
                marked     <= mk_base;
                first_face <= fst_base;
              end
              if (request.last) begin
                state <= ST_START;
              end
            end else begin
              q_hit <= hit;
              q_ref <= request.face_ref;
              state <= ST_QRES;
            end
          end
        end
        ST_QRES: begin
          strobe               <= 1'b1;
          result.result_kind   <= KIND_REMAP;
          result.boundary_slot <= '0;
          result.mapped_ref    <= q_hit ? $signed(REF_W'(map_rdata)) : q_ref;
          state                <= ST_IDLE;
        end
        ST_START: begin
          ptr_i  <= first_face;
          ptr_hi <= face_count;
          state  <= (marked == '0) ? ST_RPT : ST_IRD;
        end
        ST_IRD: begin
          state <= (ptr_i > face_count) ? ST_RPT : ST_ICHK;
        end
        ST_ICHK: begin
          if (!flag_rdata) begin
            ptr_i <= ptr_i + CW'(1);
            state <= ST_IRD;
          end else if (ptr_hi > ptr_i) begin
            ptr_j <= ptr_hi;
            state <= ST_JRD;
          end else begin
            state <= ST_RPT;
          end
        end
        ST_JRD: begin
          state <= ST_JCHK;
        end
        ST_JCHK: begin
          // search down from the back for an unflagged face above ptr_i
          if (!flag_rdata) begin
            state <= ST_SW1;
          end else if ((ptr_j - CW'(1)) > ptr_i) begin
            ptr_j <= ptr_j - CW'(1);
            state <= ST_JRD;
          end else begin
            state <= ST_RPT;
          end
        end
        ST_SW1: begin
          state <= ST_SW2;
        end
        ST_SW2: begin
          ptr_hi <= ptr_j - CW'(1);
          ptr_i  <= ptr_i + CW'(1);
          state  <= ST_IRD;
        end
        ST_RPT: begin
          strobe               <= 1'b1;
          result.result_kind   <= KIND_LOAD;
          result.boundary_slot <= SLOT_W'(face_count - marked + CW'(1));
          result.mapped_ref    <= '0;
          map_ready            <= 1'b1;
          state                <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/fpr_checker.sv */
// Port-level checks for the flag partition renumber block, bound to the top level.
module fpr_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input fpr_pkg::req_t request,
  input logic          strobe,
  input fpr_pkg::rsp_t result
);

  import fpr_pkg::*;

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result strobe while busy");

  a_remap_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.kind == KIND_REMAP)
      |=> busy ##1 (strobe && result.result_kind == KIND_REMAP))
    else $error("remap request not answered two cycles later");

  a_remap_passthru: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.kind == KIND_REMAP &&
     (request.face_ref[REF_W-1] || request.face_ref == '0))
      |-> ##2 (strobe && result.mapped_ref == $past(request.face_ref, 2)))
    else $error("non-positive reference not returned unchanged");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.kind == KIND_LOAD && !request.last)
      |=> (!busy && !strobe))
    else $error("plain load request caused busy or a result");

endmodule

bind flag_partition_renumber fpr_checker u_fpr_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .strobe  (strobe),
  .result  (result)
);
